// ----- src/matrix3x3_inverse_assert.svh -----
`ifndef MATRIX3X3_INVERSE_ASSERT_SVH
`define MATRIX3X3_INVERSE_ASSERT_SVH

// Clocked assertion, held off while reset is asserted.
`define M3I_CHECK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Implication checked in the same cycle.
`define M3I_IMPLIES(lbl, pre, post, msg) \
	`M3I_CHECK(lbl, (pre) |-> (post), msg)

// Implication checked in the following cycle.
`define M3I_NEXT(lbl, pre, post, msg) \
	`M3I_CHECK(lbl, (pre) |=> (post), msg)

`endif

// ----- src/m3i_pkg.sv -----
package m3i_pkg;
	localparam int EW   = 32;       // element width
	localparam int CFW  = 65;       // cofactor width
	localparam int DETW = 98;       // determinant width
	localparam int DW2  = 98;       // doubled determinant magnitude width
	localparam int QB   = 33;       // quotient bits per lane
	localparam int NEL  = 9;

	typedef logic signed [EW-1:0]   elem_t;
	typedef logic signed [CFW-1:0]  cof_t;
	typedef logic signed [DETW-1:0] det_t;

	typedef struct packed {
		logic ovf;
		logic neg;
	} lane_flags_t;

	typedef struct packed {
		logic        sing;
		logic [31:0] dv;
	} det_info_t;
endpackage

// ----- src/m3i_div_step.sv -----
module m3i_div_step import m3i_pkg::*; #(
	parameter int N2W = 115,
	parameter int SH  = 0
) (
	input  logic             clk,
	input  logic             en,
	input  logic [N2W-1:0]   n_in,
	input  logic [DW2-1:0]   d_in,
	input  logic [QB-1:0]    q_in,
	input  lane_flags_t      f_in,
	output logic [N2W-1:0]   n_out,
	output logic [DW2-1:0]   d_out,
	output logic [QB-1:0]    q_out,
	output lane_flags_t      f_out
);
	localparam int CMPW = DW2 + QB;

	logic [CMPW-1:0] dsh;
	logic [CMPW-1:0] next;
	logic            ge;

	assign dsh  = {{(CMPW-DW2){1'b0}}, d_in} << SH;
	assign next = {{(CMPW-N2W){1'b0}}, n_in};
	assign ge   = next >= dsh;

	// subtract the shifted divisor where it fits
	always_ff @(posedge clk) begin
		if (en) begin
			n_out <= ge ? (n_in - dsh[N2W-1:0]) : n_in;
			d_out <= d_in;
			q_out <= q_in | (QB'(ge) << SH);
			f_out <= f_in;
		end
	end
endmodule

// ----- src/m3i_front.sv -----
module m3i_front import m3i_pkg::*; (
	input  logic       clk,
	input  logic [3:0] en,
	input  elem_t      a [NEL],
	output cof_t       cof [NEL],
	output det_t       det
);
	logic signed [63:0] p_s1 [NEL];
	logic signed [63:0] q_s1 [NEL];
	elem_t              a0_s1 [3];
	elem_t              a0_s2 [3];
	cof_t               cof_s2 [NEL];
	cof_t               cof_s3 [NEL];
	cof_t               cof_s4 [NEL];
	logic signed [64:0] lo_s3 [3];
	logic signed [64:0] hi_s3 [3];
	det_t               det_s4;

	for (genvar gi = 0; gi < 3; gi++) begin : g_row
		for (genvar gj = 0; gj < 3; gj++) begin : g_col
			localparam int I1 = (gi + 1) % 3;
			localparam int I2 = (gi + 2) % 3;
			localparam int J1 = (gj + 1) % 3;
			localparam int J2 = (gj + 2) % 3;
			localparam int K  = gi * 3 + gj;
			always_ff @(posedge clk) begin
				if (en[0]) begin
					p_s1[K] <= a[I1*3+J1] * a[I2*3+J2];
					q_s1[K] <= a[I1*3+J2] * a[I2*3+J1];
				end
				if (en[1])
					cof_s2[K] <= CFW'(p_s1[K]) - CFW'(q_s1[K]);
				if (en[2])
					cof_s3[K] <= cof_s2[K];
				if (en[3])
					cof_s4[K] <= cof_s3[K];
			end
		end
	end

	// split each first-row cofactor into a low unsigned and a high signed half
	for (genvar gj = 0; gj < 3; gj++) begin : g_part
		always_ff @(posedge clk) begin
			if (en[0])
				a0_s1[gj] <= a[gj];
			if (en[1])
				a0_s2[gj] <= a0_s1[gj];
			if (en[2]) begin
				lo_s3[gj] <= a0_s2[gj] * $signed({1'b0, cof_s2[gj][31:0]});
				hi_s3[gj] <= a0_s2[gj] * $signed(cof_s2[gj][64:32]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[3])
			det_s4 <= (DETW'(hi_s3[0]) <<< 32) + DETW'(lo_s3[0])
				+ (DETW'(hi_s3[1]) <<< 32) + DETW'(lo_s3[1])
				+ (DETW'(hi_s3[2]) <<< 32) + DETW'(lo_s3[2]);
	end

	assign cof = cof_s4;
	assign det = det_s4;
endmodule

// ----- src/m3i_lane.sv -----
module m3i_lane import m3i_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic [QB+1:0] en,
	input  cof_t        c,
	input  det_t        det,
	output logic [31:0] r
);
	localparam int NUMW = 64 + 2 * FRAC_BITS;
	localparam int N2W  = ((NUMW + 1 > DW2 - 1) ? NUMW + 1 : DW2 - 1) + 1;
	localparam int CMPW = DW2 + QB;

	logic [N2W-1:0]  n_w [QB+1];
	logic [DW2-1:0]  d_w [QB+1];
	logic [QB-1:0]   q_w [QB+1];
	lane_flags_t     f_w [QB+1];

	cof_t            c_neg;
	det_t            det_neg;
	logic [63:0]     cmag;
	logic [DW2-2:0]  dmag;
	logic [NUMW:0]   num2;
	logic [N2W-1:0]  n2;
	logic [DW2-1:0]  d2;
	lane_flags_t     f_in;

	logic [QB-1:0]   limit;
	logic [QB-1:0]   mag;
	logic [31:0]     mag32;

	assign c_neg   = -c;
	assign det_neg = -det;
	assign cmag    = c[CFW-1] ? c_neg[63:0] : c[63:0];
	assign dmag    = det[DETW-1] ? det_neg[DW2-2:0] : det[DW2-2:0];
	assign num2    = {cmag, {(2*FRAC_BITS+1){1'b0}}};
	assign n2      = N2W'(num2) + N2W'(dmag);
	assign d2      = {dmag, 1'b0};
	assign f_in.neg = c[CFW-1] ^ det[DETW-1];
	assign f_in.ovf = {{(CMPW-N2W){1'b0}}, n2} >= ({{QB{1'b0}}, d2} << QB);

	always_ff @(posedge clk) begin
		if (en[0]) begin
			n_w[0] <= n2;
			d_w[0] <= d2;
			q_w[0] <= '0;
			f_w[0] <= f_in;
		end
	end

	for (genvar gs = 0; gs < QB; gs++) begin : g_step
		m3i_div_step #(.N2W(N2W), .SH(QB - 1 - gs)) u_step (
			.clk   (clk),
			.en    (en[gs+1]),
			.n_in  (n_w[gs]),
			.d_in  (d_w[gs]),
			.q_in  (q_w[gs]),
			.f_in  (f_w[gs]),
			.n_out (n_w[gs+1]),
			.d_out (d_w[gs+1]),
			.q_out (q_w[gs+1]),
			.f_out (f_w[gs+1])
		);
	end

	assign limit = f_w[QB].neg ? QB'(33'h0_8000_0000) : QB'(33'h0_7FFF_FFFF);
	assign mag   = (f_w[QB].ovf || q_w[QB] > limit) ? limit : q_w[QB];
	assign mag32 = mag[31:0];

	always_ff @(posedge clk) begin
		if (en[QB+1])
			r <= f_w[QB].neg ? (32'd0 - mag32) : mag32;
	end
endmodule

// ----- src/matrix3x3_inverse.sv -----
// Inverse of a 3x3 Q16.16 matrix by cofactors and the determinant.
// Throughput one word per cycle while the output is not stalled,
// with one restoring division step per stage in each of the nine lanes.
// Output stalls fill pipeline bubbles first, so input is taken while a word waits and a bubble is left.
// Reset (arst_n low, asynchronous) empties the pipeline; data registers are not reset.
module matrix3x3_inverse import m3i_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [287:0] s_tdata,   // a00,a01,a02,a10,a11,a12,a20,a21,a22 (32 bits each)
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [319:0] m_tdata,   // r00..r22 (32 bits each), then det_value
	output logic [0:0]   m_tuser    // singular
);
	`include "matrix3x3_inverse_assert.svh"

	// front: stages 1..4, prep: stage 5, division: 6..38, saturate: 39
	localparam int NSTG = 5 + QB + 1;

	logic [NSTG:1] v_q;
	logic [NSTG:1] en;
	elem_t         a [NEL];
	cof_t          cof [NEL];
	det_t          det;
	logic [31:0]   r [NEL];
	det_info_t     dinfo_q [NSTG:5];
	det_info_t     dinfo_in;
	det_t          det_neg;
	logic [DETW-1:0] dmag;
	logic [DETW-1:0] rnd;
	logic [DETW-1:0] dvmag;
	logic [DETW-1:0] dlim;
	logic [31:0]   dv_sat;

	for (genvar gk = 0; gk < NEL; gk++) begin : g_unpack
		assign a[gk] = s_tdata[gk*32 +: 32];
	end

	// a stage advances when it is empty or its successor advances
	always_comb begin
		en[NSTG] = !v_q[NSTG] || m_tready;
		for (int k = NSTG - 1; k >= 1; k--)
			en[k] = !v_q[k] || en[k+1];
	end

	assign s_tready = en[1];
	assign m_tvalid = v_q[NSTG];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[1])
				v_q[1] <= s_tvalid;
			for (int k = 2; k <= NSTG; k++) begin
				if (en[k])
					v_q[k] <= v_q[k-1];
			end
		end
	end

	m3i_front u_front (
		.clk (clk),
		.en  (en[4:1]),
		.a   (a),
		.cof (cof),
		.det (det)
	);

	// nine lanes, lane (i,j) divides the transposed cofactor (j,i)
	for (genvar gi = 0; gi < 3; gi++) begin : g_lrow
		for (genvar gj = 0; gj < 3; gj++) begin : g_lcol
			m3i_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
				.clk (clk),
				.en  (en[NSTG:5]),
				.c   (cof[gj*3+gi]),
				.det (det),
				.r   (r[gi*3+gj])
			);
		end
	end

	// determinant word: round half away from zero by the fixed scale, then saturate
	assign det_neg = -det;
	assign dmag    = det[DETW-1] ? det_neg : det;
	assign rnd     = dmag + (DETW'(1) << (2*FRAC_BITS - 1));
	assign dvmag   = rnd >> (2*FRAC_BITS);
	assign dlim    = det[DETW-1] ? DETW'(32'h8000_0000) : DETW'(32'h7FFF_FFFF);
	assign dv_sat  = (dvmag > dlim) ? dlim[31:0] : dvmag[31:0];
	assign dinfo_in.sing = (det == '0);
	assign dinfo_in.dv   = det[DETW-1] ? (32'd0 - dv_sat) : dv_sat;

	// hold the determinant word alongside the lanes
	always_ff @(posedge clk) begin
		if (en[5])
			dinfo_q[5] <= dinfo_in;
		for (int k = 6; k <= NSTG; k++) begin
			if (en[k])
				dinfo_q[k] <= dinfo_q[k-1];
		end
	end

	// drop every m_tdata field to zero on a singular matrix
	always_comb begin
		for (int k = 0; k < NEL; k++)
			m_tdata[k*32 +: 32] = dinfo_q[NSTG].sing ? 32'd0 : r[k];
		m_tdata[319:288] = dinfo_q[NSTG].sing ? 32'd0 : dinfo_q[NSTG].dv;
		m_tuser[0] = dinfo_q[NSTG].sing;
	end

	`M3I_IMPLIES(a_sing_zero, m_tvalid && m_tuser[0], m_tdata == '0, "singular word not zero")
	`M3I_NEXT(a_out_hold, v_q[NSTG] && !m_tready, v_q[NSTG], "output word lost while stalled")
	`M3I_IMPLIES(a_ready_full, !s_tready, v_q[NSTG] && !m_tready, "input stalled without output stall")
endmodule

// ----- test/matrix3x3_inverse_test.sv -----
module matrix3x3_inverse_test;
	import m3i_pkg::*;

	localparam int FRAC = 16;
	localparam int LATENCY = 39;

	typedef struct packed {
		logic         sing;
		logic [319:0] data;
	} inverse_word_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [287:0] s_tdata = '0;   // a00,a01,a02,a10,a11,a12,a20,a21,a22 (32 bits each)
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [319:0] m_tdata;        // r00..r22 (32 bits each), then det_value
	logic [0:0]   m_tuser;        // singular

	inverse_word_t expected_inverses[$];
	int mismatches = 0;
	int stall_mode = 0;   // 0: random stalls, 1: never stall
	int rx_wait = 0;      // cycles the receiver still holds off

	matrix3x3_inverse #(.FRAC_BITS(FRAC)) i_dut (
		.clk, .arst_n, .s_tvalid, .s_tready, .s_tdata,
		.m_tvalid, .m_tready, .m_tdata, .m_tuser
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Round |num|/|den| to nearest, ties away from zero, then saturate to 32 bits.
	function automatic logic [31:0] round_sat(logic signed [127:0] num,
			logic signed [127:0] den);
		logic [127:0] nm, dm, q;
		logic         neg;
		nm = num < 0 ? -num : num;
		dm = den < 0 ? -den : den;
		neg = (num < 0) ^ (den < 0);
		q = (2 * nm + dm) / (2 * dm);
		if (neg) begin
			if (q > 128'h8000_0000) q = 128'h8000_0000;
			return 32'(-q);
		end
		if (q > 128'h7fff_ffff) q = 128'h7fff_ffff;
		return q[31:0];
	endfunction

	// Predict inverse, determinant and singular flag for one matrix word.
	function automatic inverse_word_t predict_inverse(logic [287:0] mat);
		logic signed [127:0] m[3][3];
		logic signed [127:0] cof[3][3];
		logic signed [127:0] det;
		inverse_word_t       w;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				m[i][j] = 128'(signed'(mat[(i*3+j)*32 +: 32]));
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				cof[i][j] = m[(i+1)%3][(j+1)%3] * m[(i+2)%3][(j+2)%3]
					- m[(i+1)%3][(j+2)%3] * m[(i+2)%3][(j+1)%3];
		det = m[0][0]*cof[0][0] + m[0][1]*cof[0][1] + m[0][2]*cof[0][2];
		w = '0;
		if (det == 0) begin
			w.sing = 1'b1;
			return w;
		end
		w.data[288 +: 32] = round_sat(det, 128'sd1 <<< (2*FRAC));
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				w.data[(i*3+j)*32 +: 32] = round_sat(cof[j][i] <<< (2*FRAC), det);
		return w;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("MISMATCH %s: got %h, want %h", what, got, want);
		mismatches++;
	endtask

	// Send one matrix word after a gap (random unless one is given, and zero one time in four); hold valid until taken.
	task automatic send_matrix(logic [287:0] mat, int gap = -1);
		int wait_cycles;
		wait_cycles = gap < 0 ? $urandom_range(0, 18) : gap;
		if ($urandom_range(0, 3) == 0) wait_cycles = 0;
		repeat (wait_cycles) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= mat;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		expected_inverses.push_back(predict_inverse(mat));
	endtask

	task automatic finish_sending;
		s_tvalid <= 1'b0;
	endtask

	function automatic logic [287:0] pack9(logic [31:0] e[9]);
		logic [287:0] v;
		for (int k = 0; k < 9; k++) v[k*32 +: 32] = e[k];
		return v;
	endfunction

	function automatic logic [31:0] rand_elem();
		case ($urandom_range(0, 5))
			0: return $urandom();
			1: return 32'(signed'($urandom_range(0, 8)) - 4) << FRAC;
			2: return 32'(signed'($urandom_range(0, 4000)) - 2000);
			3: return 32'($urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff);
			default: return 32'(signed'($urandom_range(0, 1 << 20)) - (1 << 19));
		endcase
	endfunction

	// Check each output word against the oldest prediction; after each word
	// hold ready low for a randomly drawn number of cycles, unless stall_mode is 1.
	always @(posedge clk) begin
		inverse_word_t want;
		if (m_tvalid && m_tready) begin
			if (expected_inverses.size() == 0) begin
				report_mismatch("unexpected word", m_tdata[31:0], 32'd0);
			end else begin
				want = expected_inverses.pop_front();
				for (int k = 0; k < 10; k++)
					if (m_tdata[k*32 +: 32] !== want.data[k*32 +: 32])
						report_mismatch(k == 9 ? "det_value" : $sformatf("r%0d%0d", k/3, k%3),
							m_tdata[k*32 +: 32], want.data[k*32 +: 32]);
				if (m_tuser[0] !== want.sing)
					report_mismatch("singular", 32'(m_tuser[0]), 32'(want.sing));
			end
			rx_wait = $urandom_range(0, 18);
		end
		if (stall_mode == 1 || rx_wait == 0) begin
			m_tready <= 1'b1;
		end else begin
			m_tready <= 1'b0;
			rx_wait--;
		end
	end

	task automatic test_directed;
		logic [31:0] e[9];
		localparam logic [31:0] ONE = 32'h0001_0000;
		// identity
		e = '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE};
		send_matrix(pack9(e));
		// diagonal scaling, a negative entry
		e = '{2*ONE, 0, 0, 0, -4*ONE, 0, 0, 0, ONE/2};
		send_matrix(pack9(e));
		// all zero: singular
		e = '{default: 0};
		send_matrix(pack9(e));
		// repeated rows: singular
		e = '{ONE, 2*ONE, 3*ONE, ONE, 2*ONE, 3*ONE, 5, 7, 9};
		send_matrix(pack9(e));
		// tiny determinant: one-LSB diagonal, result saturates
		e = '{1, 0, 0, 0, 1, 0, 0, 0, 1};
		send_matrix(pack9(e));
		e = '{-1, 0, 0, 0, 1, 0, 0, 0, 1};
		send_matrix(pack9(e));
		// extremes of every field
		e = '{default: 32'h8000_0000};
		send_matrix(pack9(e));
		e = '{32'h7fff_ffff, 0, 0, 0, 32'h7fff_ffff, 0, 0, 0, 32'h7fff_ffff};
		send_matrix(pack9(e));
		e = '{32'h8000_0000, 0, 0, 0, 32'h8000_0000, 0, 0, 0, 32'h8000_0000};
		send_matrix(pack9(e));
		e = '{32'h7fff_ffff, 32'h8000_0000, 1, 32'hffff_ffff, 32'h7fff_ffff,
			32'h8000_0000, 3, 32'hffff_fffe, 32'h7fff_ffff};
		send_matrix(pack9(e));
		// general well-conditioned matrix
		e = '{2*ONE, ONE, 0, ONE, 3*ONE, ONE, 0, ONE, 4*ONE};
		send_matrix(pack9(e));
		// rounding: det 6 units, with an inexact one-third entry
		e = '{2*ONE, 0, 0, 0, ONE, 0, 0, 0, 3*ONE};
		send_matrix(pack9(e));
		finish_sending();
	endtask

	task automatic test_random;
		logic [31:0] e[9];
		for (int n = 0; n < 1400; n++) begin
			for (int k = 0; k < 9; k++) e[k] = rand_elem();
			if ($urandom_range(0, 9) == 0) begin
				// copy a row to make it singular
				for (int c = 0; c < 3; c++) e[6 + c] = e[c];
			end
			send_matrix(pack9(e));
			if (n == 700) begin
				// hold until the pipeline drains
				finish_sending();
				while (expected_inverses.size() != 0) @(posedge clk);
			end
		end
		finish_sending();
	endtask

	task automatic test_back_to_back;
		logic [31:0] e[9];
		stall_mode = 1;
		for (int n = 0; n < 40; n++) begin
			for (int k = 0; k < 9; k++) e[k] = rand_elem();
			send_matrix(pack9(e), 0);
		end
		finish_sending();
		stall_mode = 0;
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_back_to_back();
		test_random();
		while (expected_inverses.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#1000000;
		$display("Mismatches found");
		$finish;
	end
endmodule

// ----- filelist.f -----
+incdir+src
src/m3i_pkg.sv
src/m3i_div_step.sv
src/m3i_front.sv
src/m3i_lane.sv
src/matrix3x3_inverse.sv
test/matrix3x3_inverse_test.sv
